@@ hdl/lrupr_pkg.sv @@
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared sizes, types and a helper function for the LRU page replacement core.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   localparam int FRAMES    = 8;
   localparam int PAGE_BITS = 16;
   localparam int CFG_W     = 4;
   localparam int CNT_W     = $clog2(FRAMES + 1);
   localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CAP_RESET = 4;

   typedef logic [PAGE_BITS-1:0]                 page_type;
   typedef logic [FRAMES-1:0][PAGE_BITS-1:0]     list_type;
   typedef logic [CNT_W-1:0]                     cnt_type;
   typedef logic [IDX_W-1:0]                     idx_type;
   typedef logic [CFG_W-1:0]                     cfg_type;

   typedef struct packed {
      logic    hit;
      idx_type pos;
   } match_type;

   typedef struct packed {
      logic     valid;
      page_type page;
   } evict_type;

   // Clamps a written frame count into the range one to FRAMES.
   function automatic cnt_type cap_of(cfg_type value);
      cnt_type result;
      if (value == '0) begin
         result = cnt_type'(1);
      end else if (CNT_W'(value) > cnt_type'(FRAMES) || int'(value) > FRAMES) begin
         result = cnt_type'(FRAMES);
      end else begin
         result = cnt_type'(value);
      end
      return result;
   endfunction

endpackage

@@ hdl/lrupr_if.sv @@
// ----------------------------------------------------------------------------
// lrupr_if
// Valid/ready channels for page requests and hit/evict responses.
// ----------------------------------------------------------------------------
interface lrupr_req_if
   import lrupr_pkg::*;
   ;
   logic     valid;
   logic     ready;
   page_type page;

   modport source (output valid, output page, input ready);
   modport sink   (input valid, input page, output ready);
endinterface

interface lrupr_rsp_if
   import lrupr_pkg::*;
   ;
   logic     valid;
   logic     ready;
   logic     hit;
   logic     evicted_valid;
   page_type evicted_page;

   modport source (output valid, output hit, output evicted_valid, output evicted_page,
                   input ready);
   modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                   output ready);
endinterface

@@ hdl/lrupr_match.sv @@
// ----------------------------------------------------------------------------
// lrupr_match
// Parallel compare of a page against the resident entries, lowest hit wins.
// ----------------------------------------------------------------------------
module lrupr_match
   import lrupr_pkg::*;
(
   input  list_type  list,
   input  cnt_type   count,
   input  page_type  page,
   output match_type result
);

   logic [FRAMES-1:0] hits;

   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         hits[i] = (list[i] == page) && (cnt_type'(i) < count);
      end
   end

   always_comb begin
      result.hit = |hits;
      result.pos = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (hits[i]) begin
            result.pos = idx_type'(i);
         end
      end
   end

endmodule

@@ hdl/lrupr_state.sv @@
// ----------------------------------------------------------------------------
// lrupr_state
// Recency list, occupancy count and capacity register with their update.
// ----------------------------------------------------------------------------
module lrupr_state
   import lrupr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_en,
   input  cfg_type   csr_write_data,
   input  logic      update,
   input  page_type  page,
   input  match_type match,
   output list_type  list,
   output cnt_type   count,
   output evict_type evict
);

   list_type list_ff, list_in;
   cnt_type  count_ff, count_in;
   cnt_type  cap_ff, cap_in;
   cnt_type  limit;
   cnt_type  count_m1;
   logic     full;

   assign count_m1 = count_ff - cnt_type'(1);
   assign full     = (count_ff >= cap_ff);

   always_comb begin
      evict.valid = !match.hit && full;
      evict.page  = evict.valid ? list_ff[count_m1[IDX_W-1:0]] : '0;
   end

   always_comb begin
      if (match.hit) begin
         limit = cnt_type'(match.pos);
      end else if (full) begin
         limit = count_m1;
      end else begin
         limit = count_ff;
      end
   end

   always_comb begin
      list_in  = list_ff;
      count_in = count_ff;
      if (update) begin
         list_in[0] = page;
         for (int k = 1; k < FRAMES; k++) begin
            if (cnt_type'(k) <= limit) begin
               list_in[k] = list_ff[k-1];
            end
         end
         if (!match.hit && !full) begin
            count_in = count_ff + cnt_type'(1);
         end
      end
      cap_in = cap_ff;
      if (csr_write_en) begin
         cap_in = cap_of(csr_write_data);
         if (count_in > cap_in) begin
            count_in = cap_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      list_ff <= list_in;
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= cap_of(cfg_type'(CAP_RESET));
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

   assign list  = list_ff;
   assign count = count_ff;

   a_count_le_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("occupancy above capacity");

   a_hit_keeps_count: assert property (@(posedge clock) disable iff (reset)
      update && match.hit && !csr_write_en |=> $stable(count_ff))
      else $error("hit changed occupancy");

   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      evict.valid |-> (count_ff == cap_ff) && (count_ff != '0))
      else $error("eviction from a list that is not full");

endmodule

@@ hdl/lru_page_replacement_core.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// LRU replacement over a small set of page frames, one access per word.
// ----------------------------------------------------------------------------
// A request is held in the request register, its outcome in the response
// register. One request per cycle unless the response stalls; the parallel
// match and one-step shift of the recency list fit between the two registers.
// Reset empties the list and sets the capacity to four frames.
// ----------------------------------------------------------------------------
module lru_page_replacement_core
   import lrupr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   lrupr_req_if.sink          req,
   lrupr_rsp_if.source        rsp,
   input  logic               csr_write_en,
   input  logic [CFG_W-1:0]   csr_write_data
);

   logic      s1_valid_ff;
   page_type  s1_page_ff;
   logic      rsp_valid_ff;
   logic      rsp_hit_ff;
   evict_type rsp_evict_ff;
   logic      advance;
   logic      s1_fire;
   list_type  list;
   cnt_type   count;
   match_type match;
   evict_type evict;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign s1_fire   = s1_valid_ff && advance;
   assign req.ready = !s1_valid_ff || advance;

   lrupr_match u_match (
      .list   (list),
      .count  (count),
      .page   (s1_page_ff),
      .result (match)
   );

   lrupr_state u_state (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .update         (s1_fire),
      .page           (s1_page_ff),
      .match          (match),
      .list           (list),
      .count          (count),
      .evict          (evict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            s1_valid_ff <= req.valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
      if (req.valid && req.ready) begin
         s1_page_ff <= req.page;
      end
      if (s1_fire) begin
         rsp_hit_ff   <= match.hit;
         rsp_evict_ff <= evict;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.hit           = rsp_hit_ff;
   assign rsp.evicted_valid = rsp_evict_ff.valid;
   assign rsp.evicted_page  = rsp_evict_ff.page;

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("processed word produced no response");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_page_ff))
      else $error("request stage lost a word under backpressure");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evict_ff.valid))
      else $error("hit reported together with an eviction");

endmodule

@@ tb/sv/tb_lru_page_replacement_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement_core
// Self-checking bench for the LRU page replacement core. A table of directed
// accesses and frame counts is followed by random phases, each at its own
// frame count. Every accepted page word is run through a recency-list
// predictor, and every response word is checked against the oldest outcome.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement_core;
   import lrupr_pkg::*;

   localparam int ITEMS_PER_PHASE = 36;
   localparam int NUM_PHASES      = 11;
   localparam int LONG_HOLD       = 250;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 4;

   typedef struct packed {
      logic     hit;
      logic     evicted_valid;
      page_type evicted_page;
   } outcome_t;

   typedef struct {
      bit       is_frames;
      cfg_type  frames;
      page_type pg;
      bit       typed;
      outcome_t want;
   } dir_row_t;

   logic    clock;
   logic    reset;
   logic    csr_write_en;
   cfg_type csr_write_data;

   lrupr_req_if req_if ();
   lrupr_rsp_if rsp_if ();

   lru_page_replacement_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   page_type    lru_list [FRAMES];
   int unsigned resident;
   cfg_type     frames_reg;
   outcome_t    pending_outcomes [$];
   dir_row_t    dir_table [$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          long_hold_pending = 1'b0;

   always #10 clock = ~clock;

   function automatic int unsigned eff_cap();
      if (frames_reg == '0) return 1;
      if (int'(frames_reg) > FRAMES) return FRAMES;
      return int'(frames_reg);
   endfunction

   function automatic void apply_frames(cfg_type v);
      frames_reg = v;
      if (resident > eff_cap()) resident = eff_cap();
   endfunction

   function automatic outcome_t lru_access(page_type pg);
      outcome_t    r;
      int unsigned cap;
      int unsigned pos;
      int unsigned upto;
      int unsigned k;
      bit          found;
      r = '0;
      cap = eff_cap();
      found = 1'b0;
      pos = 0;
      if (resident > cap) resident = cap;
      for (k = 0; k < resident; k++) begin
         if (!found && lru_list[k] == pg) begin
            found = 1'b1;
            pos = k;
         end
      end
      if (!found && resident >= cap && resident > 0) begin
         r.evicted_valid = 1'b1;
         r.evicted_page = lru_list[resident-1];
         resident--;
      end
      upto = found ? pos : resident;
      for (k = upto; k > 0; k--) begin
         if (k < FRAMES) lru_list[k] = lru_list[k-1];
      end
      lru_list[0] = pg;
      if (!found) resident++;
      r.hit = found;
      return r;
   endfunction

   function automatic void add_access(page_type pg, bit typed, logic hit, logic ev,
                                      page_type evp);
      dir_row_t row;
      row.is_frames = 1'b0;
      row.frames = '0;
      row.pg = pg;
      row.typed = typed;
      row.want.hit = hit;
      row.want.evicted_valid = ev;
      row.want.evicted_page = evp;
      dir_table.push_back(row);
   endfunction

   function automatic void add_frames(cfg_type v);
      dir_row_t row;
      row.is_frames = 1'b1;
      row.frames = v;
      row.pg = '0;
      row.typed = 1'b0;
      row.want = '0;
      dir_table.push_back(row);
   endfunction

   task automatic send_page(input page_type pg, input bit typed, input outcome_t typed_want);
      outcome_t predicted;
      req_if.valid <= 1'b1;
      req_if.page <= pg;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = lru_access(pg);
      pending_outcomes.push_back(typed ? typed_want : predicted);
      @(negedge clock);
   endtask

   task automatic write_frames(input cfg_type v);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      apply_frames(v);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      outcome_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response word with no outcome waiting");
            errors++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_if.hit !== want.hit) begin
               $error("hit: expected %0d, actual %0d", want.hit, rsp_if.hit);
               errors++;
            end
            if (rsp_if.evicted_valid !== want.evicted_valid) begin
               $error("evicted_valid: expected %0d, actual %0d",
                      want.evicted_valid, rsp_if.evicted_valid);
               errors++;
            end
            if (rsp_if.evicted_page !== want.evicted_page) begin
               $error("evicted_page: expected %h, actual %h",
                      want.evicted_page, rsp_if.evicted_page);
               errors++;
            end
         end
      end
   end

   // The receiver follows a randomly chosen ready pattern, unless a long hold is pending.
   initial begin
      int         mode;
      int         span;
      int         hold_count;
      logic [7:0] pat;
      mode = 0;
      span = 0;
      hold_count = 0;
      pat = '1;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            rsp_if.ready <= 1'b0;
            hold_count++;
            if (hold_count == LONG_HOLD) begin
               hold_count = 0;
               long_hold_pending = 1'b0;
            end
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               pat = 8'($urandom);
               span = 32;
            end
            span--;
            case (mode)
               0: begin
                  rsp_if.ready <= 1'b1;
               end
               1: begin
                  rsp_if.ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_if.ready <= pat[span % 8];
               end
               default: begin
                  rsp_if.ready <= ($urandom_range(0, 7) != 0);
               end
            endcase
         end
      end
   end

   initial begin
      cfg_type     phase_frames [NUM_PHASES];
      page_type    pool [16];
      page_type    pg;
      int unsigned k;
      int          ph;
      int          n;
      int          b;
      int          burst;
      int          gap;
      int          r;

      phase_frames = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd7, 4'd6, 4'd9, 4'd4};
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.page = '0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      for (k = 0; k < FRAMES; k++) lru_list[k] = '0;
      resident = 0;
      frames_reg = cfg_type'(CAP_RESET);

      add_access(16'h0000, 1, 1'b0, 1'b0, 16'h0000);
      add_access(16'hFFFF, 1, 1'b0, 1'b0, 16'h0000);
      add_access(16'h0000, 1, 1'b1, 1'b0, 16'h0000);
      add_access(16'h0001, 0, 1'b0, 1'b0, 16'h0000);
      add_access(16'h0002, 0, 1'b0, 1'b0, 16'h0000);
      add_access(16'h0003, 1, 1'b0, 1'b1, 16'hFFFF);
      add_access(16'h0000, 0, 1'b0, 1'b0, 16'h0000);
      add_frames(4'd2);
      add_access(16'h0002, 1, 1'b0, 1'b1, 16'h0003);
      add_access(16'h0000, 0, 1'b0, 1'b0, 16'h0000);
      add_frames(4'd0);
      add_access(16'h0000, 1, 1'b1, 1'b0, 16'h0000);
      add_access(16'h5555, 1, 1'b0, 1'b1, 16'h0000);
      add_access(16'hAAAA, 1, 1'b0, 1'b1, 16'h5555);
      add_frames(4'd15);
      add_access(16'h8000, 0, 1'b0, 1'b0, 16'h0000);
      add_access(16'h7FFF, 0, 1'b0, 1'b0, 16'h0000);
      add_access(16'h0100, 0, 1'b0, 1'b0, 16'h0000);
      add_access(16'h00FF, 0, 1'b0, 1'b0, 16'h0000);
      add_access(16'h1234, 0, 1'b0, 1'b0, 16'h0000);
      add_access(16'hFEDC, 0, 1'b0, 1'b0, 16'h0000);
      add_access(16'h0F0F, 0, 1'b0, 1'b0, 16'h0000);
      add_access(16'hF0F0, 0, 1'b0, 1'b0, 16'h0000);
      add_access(16'hAAAA, 0, 1'b0, 1'b0, 16'h0000);
      add_frames(4'd8);
      add_access(16'h7FFF, 0, 1'b0, 1'b0, 16'h0000);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         if (dir_table[i].is_frames) begin
            req_if.valid <= 1'b0;
            write_frames(dir_table[i].frames);
         end else begin
            send_page(dir_table[i].pg, dir_table[i].typed, dir_table[i].want);
         end
      end
      req_if.valid <= 1'b0;

      // Most random words come from a small pool so that hits and evictions both occur.
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         write_frames(phase_frames[ph]);
         for (k = 0; k < 16; k++) pool[k] = page_type'($urandom);
         if (ph == 2) long_hold_pending = 1'b1;
         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 16);
            for (b = 0; b < burst && n < ITEMS_PER_PHASE; b++) begin
               r = $urandom_range(0, 99);
               if (r < 75) begin
                  pg = pool[$urandom_range(0, (eff_cap() + 2 > 15) ? 15 : eff_cap() + 2)];
               end else if (r < 90) begin
                  pg = pool[$urandom_range(0, 15)];
               end else begin
                  pg = page_type'($urandom);
               end
               send_page(pg, 1'b0, '0);
               n++;
               if (ph == 5 && n == 18) begin
                  req_if.valid <= 1'b0;
                  while (pending_outcomes.size() != 0) @(posedge clock);
                  @(negedge clock);
               end
            end
            gap = (ph == 7) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
               req_if.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         req_if.valid <= 1'b0;
      end

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
